FILE: hdl/ldsr_pkg.sv
// Shared types and constants for the drift servo resampler.
package ldsr_pkg;

  localparam int unsigned Knee       = 24000;
  localparam int unsigned Headroom   = 8767;
  localparam int unsigned UnityGain  = 4096;
  localparam int unsigned AlphaQ16   = 1311;
  localparam int unsigned DepthCap   = 96000;
  localparam int unsigned MaxPpmQ16  = 131072000;
  localparam int unsigned PpmDiv     = 1000000;
  localparam logic [31:0] Recip3     = 32'hAAAAAAAB;
  localparam int unsigned LimQuotW   = 14;

  localparam logic CMD_SAMPLE  = 1'b0;
  localparam logic CMD_FRAME   = 1'b1;
  localparam logic KIND_AUDIO  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;
  localparam logic REG_GAIN    = 1'b0;
  localparam logic REG_TARGET  = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic [25:0]        depth_q16;
  } work_t;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic [9:0]         avg_ms;
    logic signed [11:0] adjust_ppm;
    logic               last;
  } result_t;

endpackage

FILE: hdl/ldsr_fifo.sv
// Two-entry queue for packed items.
module ldsr_fifo #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             rd_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  logic [Width-1:0] mem_q [2];
  logic             wptr_q, rptr_q;
  logic [1:0]       cnt_q;
  logic             do_wr, do_rd;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (do_wr) wptr_q <= ~wptr_q;
      if (do_rd) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + 2'(do_wr) - 2'(do_rd);
    end
  end

endmodule

FILE: hdl/ldsr_front.sv
// Front end: takes items, applies gain and soft-knee limiter (bypassed at unity gain), scales ring depth.
module ldsr_front import ldsr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               full_o,
  input  logic               command_i,
  input  logic signed [15:0] left_in_i,
  input  logic signed [15:0] right_in_i,
  input  logic [16:0]        ring_depth_i,
  input  logic [14:0]        gain_i,
  output logic               work_wr_o,
  output work_t              work_o,
  input  logic               work_full_i
);

  typedef enum logic [4:0] {
    FR_IDLE = 5'b00001,
    FR_MUL  = 5'b00010,
    FR_PREP = 5'b00100,
    FR_DIV  = 5'b01000,
    FR_PUSH = 5'b10000
  } front_state_e;

  front_state_e       state_q, state_d;
  logic               cmd_q;
  logic [16:0]        ring_q;
  logic [25:0]        depth_q, depth_d;
  logic [3:0]         cnt_q, cnt_d;
  logic signed [15:0] x_q   [2];
  logic [18:0]        mag_q [2], mag_d [2];
  logic               neg_q [2], neg_d [2];
  logic               ovr_q [2], ovr_d [2];
  logic [17:0]        rem_q [2], rem_d [2];
  logic [17:0]        den_q [2], den_d [2];
  logic [13:0]        shq_q [2], shq_d [2];
  logic signed [15:0] y     [2];

  logic [16:0] ring_cap;
  logic [59:0] dprod;

  assign full_o = (state_q != FR_IDLE);
  assign ring_cap = (ring_q > 17'(DepthCap)) ? 17'(DepthCap) : ring_q;
  assign dprod = {ring_cap, 11'd0} * Recip3;
  assign depth_d = dprod[58:33];

  always_comb begin
    logic signed [31:0] prod;
    logic [31:0]        aprod;
    logic [18:0]        over;
    logic [32:0]        num;
    logic [18:0]        r2;
    logic [14:0]        lim;
    for (int i = 0; i < 2; i++) begin
      prod   = $signed({{16{x_q[i][15]}}, x_q[i]}) * $signed({17'd0, gain_i});
      aprod  = prod[31] ? 32'(-prod) : 32'(prod);
      mag_d[i] = mag_q[i];
      neg_d[i] = neg_q[i];
      ovr_d[i] = ovr_q[i];
      rem_d[i] = rem_q[i];
      den_d[i] = den_q[i];
      shq_d[i] = shq_q[i];
      over   = mag_q[i] - 19'(Knee);
      num    = 33'(over) * 33'(Headroom);
      r2     = {rem_q[i], shq_q[i][13]};
      lim    = 15'(Knee) + 15'(shq_q[i]);
      y[i]   = '0;
      case (state_q)
        FR_MUL: begin
          mag_d[i] = aprod[30:12];
          neg_d[i] = prod[31];
        end
        FR_PREP: begin
          ovr_d[i] = mag_q[i] > 19'(Knee);
          rem_d[i] = {1'b0, num[30:14]};
          shq_d[i] = num[13:0];
          den_d[i] = 18'(over + 19'(Headroom));
        end
        FR_DIV: begin
          if (r2 >= {1'b0, den_q[i]}) begin
            rem_d[i] = 18'(r2 - {1'b0, den_q[i]});
            shq_d[i] = {shq_q[i][12:0], 1'b1};
          end else begin
            rem_d[i] = r2[17:0];
            shq_d[i] = {shq_q[i][12:0], 1'b0};
          end
        end
        default: ;
      endcase
      if (gain_i == 15'(UnityGain)) begin
        y[i] = x_q[i];
      end else begin
        y[i] = ovr_q[i] ? $signed({1'b0, lim}) : $signed(mag_q[i][15:0]);
        if (neg_q[i]) y[i] = -y[i];
      end
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    work_wr_o = 1'b0;
    work_o.cmd       = cmd_q;
    work_o.left      = y[0];
    work_o.right     = y[1];
    work_o.depth_q16 = depth_q;
    case (state_q)
      FR_IDLE: if (push_i) state_d = FR_MUL;
      FR_MUL:  state_d = (cmd_q == CMD_FRAME) ? FR_PUSH : FR_PREP;
      FR_PREP: begin
        state_d = FR_DIV;
        cnt_d   = 4'(LimQuotW);
      end
      FR_DIV: begin
        cnt_d = cnt_q - 4'd1;
        if (cnt_q == 4'd1) state_d = FR_PUSH;
      end
      FR_PUSH: begin
        if (!work_full_i) begin
          work_wr_o = 1'b1;
          state_d   = FR_IDLE;
        end
      end
      default: state_d = FR_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == FR_IDLE && push_i) begin
      cmd_q  <= command_i;
      x_q[0] <= left_in_i;
      x_q[1] <= right_in_i;
      ring_q <= ring_depth_i;
    end
    if (state_q == FR_MUL) depth_q <= depth_d;
    for (int i = 0; i < 2; i++) begin
      mag_q[i] <= mag_d[i];
      neg_q[i] <= neg_d[i];
      ovr_q[i] <= ovr_d[i];
      rem_q[i] <= rem_d[i];
      den_q[i] <= den_d[i];
      shq_q[i] <= shq_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FR_IDLE;
      cnt_q   <= 4'd0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

FILE: hdl/ldsr_back.sv
// Back end: linear interpolation resampler and depth servo.
module ldsr_back import ldsr_pkg::*; #(
  parameter int unsigned FracBits = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        work_empty_i,
  input  work_t       work_i,
  output logic        work_rd_o,
  input  logic [9:0]  target_i,
  output logic        res_wr_o,
  output result_t     res_o,
  input  logic        res_full_i
);

  localparam int unsigned PW   = FracBits + 18;
  localparam int unsigned KW   = FracBits + 12;
  localparam int unsigned KHiW = KW - 26;
  localparam int unsigned SumW = KW + 27;
  // ceil(2^(FracBits+31) / 1e6); exact for ppm magnitudes below 2^47 / 1e6
  localparam logic [KW-1:0] RecipK =
    (KW)'(((128'd1 << (FracBits + 31)) + 128'(PpmDiv - 1)) / 128'(PpmDiv));

  typedef enum logic [7:0] {
    BK_IDLE  = 8'b00000001,
    BK_MUL   = 8'b00000010,
    BK_EMIT  = 8'b00000100,
    BK_AVG   = 8'b00001000,
    BK_UPD   = 8'b00010000,
    BK_SERVO = 8'b00100000,
    BK_RECIP = 8'b01000000,
    BK_STAT  = 8'b10000000
  } back_state_e;

  back_state_e              state_q, state_d;
  logic signed [15:0]       cur_l_q, cur_r_q, prev_l_q, prev_r_q;
  logic [FracBits:0]        phase_q, phase_d;
  logic signed [FracBits-1:0] ra_q, ra_d;
  logic [25:0]              avg_q, avg_d, d_q;
  logic                     second_q, second_d;
  logic signed [PW-1:0]     prod_l_q, prod_r_q;
  logic signed [38:0]       dprod_q;
  logic signed [27:0]       ppm_q;
  logic [52:0]              rp_lo_q;
  logic [KHiW+26:0]         rp_hi_q;

  logic [FracBits+1:0] one_w, step, pnext;
  logic                pge;
  logic signed [16:0]  diff_l, diff_r;
  logic signed [PW-1:0] frac_ext, acc_l, acc_r, sh_l, sh_r;
  logic [15:0]         out_l, out_r;
  logic signed [26:0]  dd, err;
  logic signed [31:0]  ppm_raw;
  logic signed [27:0]  ppm_cl;
  logic [26:0]         ppm_mag, held_mag;
  logic [SumW-1:0]     rsum;
  logic [25:0]         avg_inc;
  logic [FracBits-1:0] qmag;
  logic [11:0]         adj_mag;

  assign one_w  = (FracBits+2)'(1) << FracBits;
  assign step   = one_w - (FracBits+2)'(ra_q);
  assign pnext  = {1'b0, phase_q} + step;
  assign pge    = pnext >= one_w;

  assign diff_l   = 17'(cur_l_q) - 17'(prev_l_q);
  assign diff_r   = 17'(cur_r_q) - 17'(prev_r_q);
  assign frac_ext = $signed({{18{1'b0}}, phase_q[FracBits-1:0]});

  assign acc_l = ((PW)'(prev_l_q) <<< FracBits) + prod_l_q;
  assign acc_r = ((PW)'(prev_r_q) <<< FracBits) + prod_r_q;
  assign sh_l  = acc_l >>> FracBits;
  assign sh_r  = acc_r >>> FracBits;
  assign out_l = sh_l[15:0] + 16'(acc_l[PW-1] && (acc_l[FracBits-1:0] != '0));
  assign out_r = sh_r[15:0] + 16'(acc_r[PW-1] && (acc_r[FracBits-1:0] != '0));

  assign dd      = $signed({1'b0, d_q}) - $signed({1'b0, avg_q});
  assign avg_inc = 26'(dprod_q >>> 16);
  assign err     = $signed({1'b0, target_i, 16'd0}) - $signed({1'b0, avg_q});
  assign ppm_raw = (32'(err) <<< 5) - (32'(err) <<< 1);
  assign ppm_cl  = (ppm_raw > $signed(32'(MaxPpmQ16)))  ?  28'(MaxPpmQ16) :
                   (ppm_raw < -$signed(32'(MaxPpmQ16))) ? -28'(MaxPpmQ16) :
                   ppm_raw[27:0];
  assign ppm_mag  = ppm_cl[27] ? 27'(-ppm_cl) : ppm_cl[26:0];
  assign held_mag = ppm_q[27] ? 27'(-ppm_q) : ppm_q[26:0];
  // magnitude * 2^(FracBits-16) / 1e6 from two partial products
  assign rsum     = ((SumW)'(rp_hi_q) << 26) + (SumW)'(rp_lo_q);
  assign qmag     = (FracBits)'(rsum >> 47);
  assign adj_mag  = {1'b0, held_mag[26:16]};

  always_comb begin
    state_d  = state_q;
    phase_d  = phase_q;
    ra_d     = ra_q;
    avg_d    = avg_q;
    second_d = second_q;
    work_rd_o = 1'b0;
    res_wr_o  = 1'b0;
    res_o.kind       = KIND_AUDIO;
    res_o.left       = $signed(out_l);
    res_o.right      = $signed(out_r);
    res_o.avg_ms     = '0;
    res_o.adjust_ppm = '0;
    res_o.last       = second_q || pge;
    case (state_q)
      BK_IDLE: begin
        if (!work_empty_i) begin
          work_rd_o = 1'b1;
          second_d  = 1'b0;
          if (work_i.cmd == CMD_FRAME) begin
            state_d = BK_AVG;
          end else if (phase_q[FracBits]) begin
            // no output for this item
            phase_d = {1'b0, phase_q[FracBits-1:0]};
          end else begin
            state_d = BK_MUL;
          end
        end
      end
      BK_MUL: state_d = BK_EMIT;
      BK_EMIT: begin
        if (!res_full_i) begin
          res_wr_o = 1'b1;
          if (second_q || pge) begin
            phase_d = pge ? (FracBits+1)'(pnext - one_w) : '0;
            state_d = BK_IDLE;
          end else begin
            phase_d  = pnext[FracBits:0];
            second_d = 1'b1;
            state_d  = BK_MUL;
          end
        end
      end
      BK_AVG: state_d = BK_UPD;
      BK_UPD: begin
        avg_d   = avg_q + avg_inc;
        state_d = BK_SERVO;
      end
      BK_SERVO: state_d = BK_RECIP;
      BK_RECIP: state_d = BK_STAT;
      BK_STAT: begin
        res_o.kind       = KIND_STATUS;
        res_o.left       = '0;
        res_o.right      = '0;
        res_o.avg_ms     = avg_q[25:16];
        res_o.adjust_ppm = ppm_q[27] ? $signed(-adj_mag) : $signed(adj_mag);
        res_o.last       = 1'b1;
        if (!res_full_i) begin
          res_wr_o = 1'b1;
          ra_d     = ppm_q[27] ? $signed(-qmag) : $signed(qmag);
          state_d  = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == BK_IDLE && !work_empty_i) begin
      cur_l_q <= work_i.left;
      cur_r_q <= work_i.right;
      d_q     <= work_i.depth_q16;
    end
    prod_l_q <= (PW)'(diff_l) * frac_ext;
    prod_r_q <= (PW)'(diff_r) * frac_ext;
    dprod_q  <= 39'(dd) * $signed(39'(AlphaQ16));
    if (state_q == BK_SERVO) ppm_q <= ppm_cl;
    if (state_q == BK_RECIP) begin
      rp_lo_q <= 53'(held_mag) * 53'(RecipK[25:0]);
      rp_hi_q <= (KHiW+27)'(held_mag) * (KHiW+27)'(RecipK[KW-1:26]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= BK_IDLE;
      phase_q  <= '0;
      ra_q     <= '0;
      avg_q    <= '0;
      second_q <= 1'b0;
      prev_l_q <= '0;
      prev_r_q <= '0;
    end else begin
      state_q  <= state_d;
      phase_q  <= phase_d;
      ra_q     <= ra_d;
      avg_q    <= avg_d;
      second_q <= second_d;
      if ((state_q == BK_IDLE && !work_empty_i && work_i.cmd == CMD_SAMPLE &&
           phase_q[FracBits]) ||
          (state_q == BK_EMIT && !res_full_i && (second_q || pge))) begin
        prev_l_q <= (state_q == BK_IDLE) ? work_i.left  : cur_l_q;
        prev_r_q <= (state_q == BK_IDLE) ? work_i.right : cur_r_q;
      end
    end
  end

endmodule

FILE: hdl/limiter_drift_servo_resampler.sv
// Top level: limiter front end, work queue, resampler/servo back end, result queue.
// Sample item: front multiply, setup, 14-step limiter divide, hand-off; back takes it, then
//   multiplies and emits each output pair (0 to 2 pairs).
// Frame item: front multiply and hand-off; back take, average, update, clamp, recip, report.
// Front takes no new item until hand-off; hand-off, emit and report wait on a full queue.
// Reset (async, low) clears phase, last pair, depth average, rate adjust; gain 4096, target 100 ms.
module limiter_drift_servo_resampler import ldsr_pkg::*; #(
  parameter int unsigned FRAC_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic               command_i,
  input  logic signed [15:0] left_in_i,
  input  logic signed [15:0] right_in_i,
  input  logic [16:0]        ring_depth_i,
  output logic               empty,
  input  logic               pop,
  output logic               kind_o,
  output logic signed [15:0] left_out_o,
  output logic signed [15:0] right_out_o,
  output logic [9:0]         smoothed_depth_ms_o,
  output logic signed [11:0] adjust_ppm_o,
  output logic               last_o,
  input  logic               cfg_we_i,
  input  logic               cfg_addr_i,
  input  logic [14:0]        cfg_wdata_i
);

  localparam int unsigned WorkW = $bits(work_t);
  localparam int unsigned ResW  = $bits(result_t);

  logic [14:0] gain_q;
  logic [9:0]  target_q;

  work_t   work_in, work_out;
  result_t res_in, res_out;
  logic    work_wr, work_full, work_rd, work_empty;
  logic    res_wr, res_full;

  // config registers; the user must write them only while idle, the block does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q   <= 15'(UnityGain);
      target_q <= 10'd100;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_GAIN:   gain_q   <= cfg_wdata_i;
        REG_TARGET: target_q <= cfg_wdata_i[9:0];
        default: ;
      endcase
    end
  end

  ldsr_front u_front (
    .clk_i, .rst_ni,
    .push_i       (push),
    .full_o       (full),
    .command_i, .left_in_i, .right_in_i, .ring_depth_i,
    .gain_i       (gain_q),
    .work_wr_o    (work_wr),
    .work_o       (work_in),
    .work_full_i  (work_full)
  );

  ldsr_fifo #(.Width(WorkW)) u_work_q (
    .clk_i, .rst_ni,
    .wr_i    (work_wr),
    .wdata_i (work_in),
    .full_o  (work_full),
    .rd_i    (work_rd),
    .rdata_o (work_out),
    .empty_o (work_empty)
  );

  ldsr_back #(.FracBits(FRAC_BITS)) u_back (
    .clk_i, .rst_ni,
    .work_empty_i (work_empty),
    .work_i       (work_out),
    .work_rd_o    (work_rd),
    .target_i     (target_q),
    .res_wr_o     (res_wr),
    .res_o        (res_in),
    .res_full_i   (res_full)
  );

  // result queue: head is presented on the output ports
  ldsr_fifo #(.Width(ResW)) u_res_q (
    .clk_i, .rst_ni,
    .wr_i    (res_wr),
    .wdata_i (res_in),
    .full_o  (res_full),
    .rd_i    (pop),
    .rdata_o (res_out),
    .empty_o (empty)
  );

  assign kind_o              = res_out.kind;
  assign left_out_o          = res_out.left;
  assign right_out_o         = res_out.right;
  assign smoothed_depth_ms_o = res_out.avg_ms;
  assign adjust_ppm_o        = res_out.adjust_ppm;
  assign last_o              = res_out.last;

`ifndef ASSERT_OFF
  a_no_work_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(work_wr && work_full)) else $error("work queue overflow");
  a_no_res_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(res_wr && res_full)) else $error("result queue overflow");
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o == KIND_STATUS) |-> (last_o && left_out_o == 16'sd0 &&
    right_out_o == 16'sd0)) else $error("bad status item");
  a_audio_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o == KIND_AUDIO) |-> (smoothed_depth_ms_o == 10'd0 &&
    adjust_ppm_o == 12'sd0)) else $error("bad audio item");
`endif

endmodule

FILE: sim/tb.sv
// Self-checking testbench for the drift servo resampler.
`timescale 1ns / 100ps

module tb;
  import ldsr_pkg::*;

  typedef struct {
    logic              cmd;
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic [16:0]        depth;
  } stim_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               push = 1'b0;
  logic               full;
  logic               command_i = CMD_SAMPLE;
  logic signed [15:0] left_in_i = '0;
  logic signed [15:0] right_in_i = '0;
  logic [16:0]        ring_depth_i = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic               kind_o;
  logic signed [15:0] left_out_o;
  logic signed [15:0] right_out_o;
  logic [9:0]         smoothed_depth_ms_o;
  logic signed [11:0] adjust_ppm_o;
  logic               last_o;
  logic               cfg_we_i = 1'b0;
  logic               cfg_addr_i = REG_GAIN;
  logic [14:0]        cfg_wdata_i = '0;

  limiter_drift_servo_resampler dut (.*);

  always #5 clk_i = ~clk_i;

  // Sample pairs and frame updates waiting to be offered, and the results
  // the predictor says must come out, oldest first.
  stim_t   pending_items[$];
  result_t expected_results[$];
  int      fail_count = 0;

  // Idle odds in percent, set per phase.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  // Long receiver hold-off: requested once by the sequencer, counted in its own process.
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  int   hold_cnt = 0;

  // Predictor state, a copy of what the block keeps.
  localparam longint PhaseOne = 64'sd1 <<< 32;
  longint gain_q12 = 4096;
  longint target_ms = 100;
  longint phase_acc = 0;
  longint last_l = 0;
  longint last_r = 0;
  longint depth_avg_q16 = 0;
  longint rate_trim = 0;

  // Gain, then the soft knee when the gain is not unity.
  function automatic longint apply_gain(longint x);
    longint s, a, over;
    if (gain_q12 == UnityGain) return x;
    s = (x * gain_q12) / 4096;
    a = (s < 0) ? -s : s;
    if (a > Knee) begin
      over = a - Knee;
      a = Knee + (Headroom * over) / (over + Headroom);
    end
    return (s < 0) ? -a : a;
  endfunction

  function automatic longint interp(longint l0, longint l1, longint frac);
    longint acc;
    acc = l0 * PhaseOne + (l1 - l0) * frac;
    return acc / PhaseOne;
  endfunction

  // Works out the results of one accepted item and queues them.
  task automatic predict_results(logic cmd, longint lin, longint rin, longint dep);
    result_t r;
    longint d, delta, inc, err, ppm, l1, r1, step;
    int n;
    r = '0;
    if (cmd == CMD_FRAME) begin
      if (dep > DepthCap) dep = DepthCap;
      d = (dep <<< 16) / 96;
      delta = AlphaQ16 * (d - depth_avg_q16);
      if (delta >= 0) inc = delta >>> 16;
      else inc = -(((-delta) + 65535) >>> 16);
      depth_avg_q16 += inc;
      err = target_ms * 65536 - depth_avg_q16;
      ppm = err * 30;
      if (ppm > longint'(MaxPpmQ16)) ppm = longint'(MaxPpmQ16);
      if (ppm < -longint'(MaxPpmQ16)) ppm = -longint'(MaxPpmQ16);
      rate_trim = (ppm * 65536) / 1000000;
      r.kind = KIND_STATUS;
      r.avg_ms = 10'(depth_avg_q16 >>> 16);
      r.adjust_ppm = 12'(ppm / 65536);
      r.last = 1'b1;
      expected_results = {expected_results, r};
    end else begin
      l1 = apply_gain(lin);
      r1 = apply_gain(rin);
      step = PhaseOne - rate_trim;
      n = 0;
      while (n < 2 && phase_acc < PhaseOne) begin
        r = '0;
        r.kind = KIND_AUDIO;
        r.left = 16'(interp(last_l, l1, phase_acc));
        r.right = 16'(interp(last_r, r1, phase_acc));
        expected_results = {expected_results, r};
        n++;
        phase_acc += step;
      end
      // only the final pair of this sample carries the last flag
      if (n > 0) expected_results[$].last = 1'b1;
      phase_acc = (phase_acc >= PhaseOne) ? phase_acc - PhaseOne : 0;
      last_l = l1;
      last_r = r1;
    end
  endtask

  // Driver: holds an offered item until taken, idles at random otherwise.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) begin
        predict_results(command_i, longint'(left_in_i), longint'(right_in_i),
                        longint'(ring_depth_i));
        void'(pending_items.pop_front());
      end
      if (!(push && full)) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          push <= 1'b1;
          command_i <= pending_items[0].cmd;
          left_in_i <= pending_items[0].left;
          right_in_i <= pending_items[0].right;
          ring_depth_i <= pending_items[0].depth;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Hold-off counter for the receiver.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_req && !hold_done) begin
        hold_done <= 1'b1;
        hold_cnt <= 400;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
      end
    end
  end

  // Monitor: checks each taken result against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: kind %0d", kind_o);
          fail_count++;
        end else begin
          result_t e;
          e = expected_results.pop_front();
          if (kind_o !== e.kind) begin
            $error("kind: expected %0d got %0d", e.kind, kind_o); fail_count++;
          end
          if (left_out_o !== e.left) begin
            $error("left_out: expected %0d got %0d", e.left, left_out_o); fail_count++;
          end
          if (right_out_o !== e.right) begin
            $error("right_out: expected %0d got %0d", e.right, right_out_o); fail_count++;
          end
          if (smoothed_depth_ms_o !== e.avg_ms) begin
            $error("smoothed_depth_ms: expected %0d got %0d", e.avg_ms,
                   smoothed_depth_ms_o);
            fail_count++;
          end
          if (adjust_ppm_o !== e.adjust_ppm) begin
            $error("adjust_ppm: expected %0d got %0d", e.adjust_ppm, adjust_ppm_o);
            fail_count++;
          end
          if (last_o !== e.last) begin
            $error("last: expected %0d got %0d", e.last, last_o); fail_count++;
          end
        end
      end
      if (hold_cnt > 0 || (hold_req && !hold_done)) begin
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic add_sample(logic signed [15:0] l, logic signed [15:0] r);
    stim_t s;
    s.cmd = CMD_SAMPLE; s.left = l; s.right = r; s.depth = 17'($urandom);
    pending_items = {pending_items, s};
  endtask

  task automatic add_frame(logic [16:0] d);
    stim_t s;
    s.cmd = CMD_FRAME; s.left = 16'($urandom); s.right = 16'($urandom); s.depth = d;
    pending_items = {pending_items, s};
  endtask

  // Waits for all items out and all results back, then lets the block settle
  // (a sample may leave the block without any result).
  task automatic drain();
    while (pending_items.size() > 0 || push || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [14:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_GAIN) gain_q12 = val;
    else target_ms = val;
  endtask

  // Mostly samples; frames half in a tight depth band around the target, so the servo
  // moves but stays off the clamp part of the time, half full range.
  task automatic add_random(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 20) begin
        if ($urandom_range(1)) add_frame(17'($urandom_range(131071)));
        else add_frame(17'(target_ms * 96 + $urandom_range(3000) - 1500));
      end else begin
        add_sample(16'($urandom), 16'($urandom));
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: unity gain, sample extremes, depth extremes and a deep ring.
    send_idle_pct = 18; recv_idle_pct = 59;
    add_sample(16'sh7FFF, -16'sh8000);
    add_sample(-16'sh8000, 16'sh7FFF);
    add_sample(0, -1);
    add_frame(0);
    add_frame(17'd96000);
    add_frame(17'h1FFFF);
    add_sample(16'sh5555, -16'sh2AAB);
    add_sample(-1, 0);
    drain();

    // Full gain drives both channels into the knee; target at its top.
    write_reg(REG_GAIN, 15'd32767);
    write_reg(REG_TARGET, 15'd1000);
    for (int i = 0; i < 6; i++) add_frame(0);
    add_sample(16'sh7FFF, -16'sh8000);
    add_sample(-16'sh8000, 16'sh7FFF);
    add_sample(16'sh1800, -16'sh1800);
    add_sample(0, 1);
    add_sample(16'sh2EE0, -16'sh2EE1);
    drain();

    // Zero gain, target zero: servo swings the other way.
    write_reg(REG_GAIN, 15'd0);
    write_reg(REG_TARGET, 15'd0);
    for (int i = 0; i < 4; i++) add_frame(17'd96000);
    add_sample(16'sh7FFF, -16'sh8000);
    add_sample(-16'sh8000, 16'sh7FFF);
    drain();

    // Random phase with the long receiver hold-off in the middle.
    write_reg(REG_GAIN, 15'd8192);
    write_reg(REG_TARGET, 15'd100);
    add_random(190);
    repeat (50) @(posedge clk_i);
    hold_req <= 1'b1;
    drain();

    send_idle_pct = 59; recv_idle_pct = 18;
    write_reg(REG_GAIN, 15'd4096);
    write_reg(REG_TARGET, 15'($urandom_range(1000)));
    add_random(190);
    drain();

    send_idle_pct = 0; recv_idle_pct = 0;
    write_reg(REG_GAIN, 15'($urandom_range(32767)));
    write_reg(REG_TARGET, 15'd1000);
    add_random(190);
    drain();

    write_reg(REG_GAIN, 15'd32767);
    write_reg(REG_TARGET, 15'd0);
    add_random(190);
    drain();

    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
